// ===== rtl/afc_pkg.sv =====
package afc_pkg;

    localparam int unsigned FRAME_LEN = 17;
    localparam int unsigned POS_W     = $clog2(FRAME_LEN + 1);
    localparam int unsigned NUM_WORDS = 3;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned BYTES_PER_WORD = WORD_W / 8;
    localparam int unsigned FIRST_WORD_BYTE = 3;
    localparam int unsigned CMD_BYTE   = 1;
    localparam int unsigned ERROR_BYTE = 15;
    localparam int unsigned SUM_BYTE   = 16;

    localparam logic [7:0]        CMD_RESET = 8'h04;
    localparam logic [WORD_W-1:0] FAIL_WORD = 32'hC47A0000;

    typedef enum logic [1:0] {
        STATUS_OK  = 2'd0,
        STATUS_CMD = 2'd1,
        STATUS_SUM = 2'd2
    } status_t;

    typedef struct packed {
        logic [WORD_W-1:0] angle_x;
        logic [WORD_W-1:0] angle_y;
        logic [WORD_W-1:0] angle_z;
        status_t           status;
        logic [7:0]        sensor_error;
        logic              valid_res;
    } result_t;

endpackage

// ===== rtl/afc_frame.sv =====
module afc_frame (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                byte_fire,
    input  logic [7:0]          rx_byte,
    input  logic                frame_start,
    input  logic [7:0]          expected_command,
    output logic                at_last_byte,
    output logic                result_fire,
    output afc_pkg::result_t    result
);

    logic [afc_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [afc_pkg::POS_W-1:0]  pos_eff;
    logic [7:0]                 sum_reg, sum_next;
    logic                       cmd_ok_reg, cmd_ok_next;
    logic [7:0]                 err_reg, err_next;
    logic [afc_pkg::WORD_W-1:0] word_reg  [afc_pkg::NUM_WORDS];
    logic [afc_pkg::WORD_W-1:0] word_next [afc_pkg::NUM_WORDS];
    afc_pkg::status_t           status;

    assign pos_eff      = frame_start ? '0 : pos_reg;
    assign at_last_byte = (pos_reg == afc_pkg::POS_W'(afc_pkg::SUM_BYTE));

    always_comb begin
        pos_next    = pos_reg;
        sum_next    = sum_reg;
        cmd_ok_next = cmd_ok_reg;
        err_next    = err_reg;
        for (int k = 0; k < afc_pkg::NUM_WORDS; k++) begin
            word_next[k] = word_reg[k];
        end
        if (byte_fire && pos_eff < afc_pkg::POS_W'(afc_pkg::FRAME_LEN)) begin
            pos_next = pos_eff + 1'b1;
            if (pos_eff == '0) begin
                sum_next    = '0;
                cmd_ok_next = 1'b0;
            end else if (pos_eff < afc_pkg::POS_W'(afc_pkg::SUM_BYTE)) begin
                sum_next = sum_reg + rx_byte;
                if (pos_eff == afc_pkg::POS_W'(afc_pkg::CMD_BYTE)) begin
                    cmd_ok_next = (rx_byte == expected_command);
                end
                if (pos_eff == afc_pkg::POS_W'(afc_pkg::ERROR_BYTE)) begin
                    err_next = rx_byte;
                end
                // little-endian: lowest byte of each word arrives first
                for (int k = 0; k < afc_pkg::NUM_WORDS; k++) begin
                    for (int j = 0; j < afc_pkg::BYTES_PER_WORD; j++) begin
                        if (pos_eff == afc_pkg::POS_W'(afc_pkg::FIRST_WORD_BYTE
                                + k * afc_pkg::BYTES_PER_WORD + j)) begin
                            word_next[k][8*j +: 8] = rx_byte;
                        end
                    end
                end
            end
        end
    end

    assign result_fire = byte_fire && (pos_eff == afc_pkg::POS_W'(afc_pkg::SUM_BYTE));

    always_comb begin
        if (!cmd_ok_reg) begin
            status = afc_pkg::STATUS_CMD;
        end else if (sum_reg != rx_byte) begin
            status = afc_pkg::STATUS_SUM;
        end else begin
            status = afc_pkg::STATUS_OK;
        end
        result.status = status;
        if (status == afc_pkg::STATUS_OK) begin
            result.angle_x      = word_reg[0];
            result.angle_y      = word_reg[1];
            result.angle_z      = word_reg[2];
            result.sensor_error = err_reg;
            result.valid_res    = (err_reg == 8'd0);
        end else begin
            result.angle_x      = afc_pkg::FAIL_WORD;
            result.angle_y      = afc_pkg::FAIL_WORD;
            result.angle_z      = afc_pkg::FAIL_WORD;
            result.sensor_error = 8'd0;
            result.valid_res    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else begin
            pos_reg <= pos_next;
        end
        sum_reg    <= sum_next;
        cmd_ok_reg <= cmd_ok_next;
        err_reg    <= err_next;
        for (int k = 0; k < afc_pkg::NUM_WORDS; k++) begin
            word_reg[k] <= word_next[k];
        end
    end

endmodule

// ===== rtl/afc_out.sv =====
module afc_out (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  afc_pkg::result_t load_data,
    input  logic             m_ready,
    output logic             full,
    output logic             m_valid,
    output afc_pkg::result_t m_data
);

    logic             valid_reg, valid_next;
    afc_pkg::result_t data_reg;

    // a new load may replace a result in the same cycle it is taken
    always_comb begin
        valid_next = valid_reg;
        if (m_ready) begin
            valid_next = 1'b0;
        end
        if (load) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (load) begin
            data_reg <= load_data;
        end
    end

    assign full    = valid_reg;
    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

// ===== rtl/angle_frame_checker.sv =====
// The result is registered when byte 16 transfers and is on the m_ outputs in the cycle after.
// Throughput: one byte per cycle; the only stall is the byte that follows byte 15
// of a frame (byte 16 or a new frame start) while the previous result is still
// held in the output register and m_ready is low.
// Reset (aresetn low, synchronous): byte count to zero, output register empty,
// expected command register back to 0x04.
module angle_frame_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        s_frame_start,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_angle_x,
    output logic [31:0] m_angle_y,
    output logic [31:0] m_angle_z,
    output logic [1:0]  m_status,
    output logic [7:0]  m_sensor_error,
    output logic        m_valid_res
);

    logic [7:0]       cmd_value_reg;
    logic             at_last_byte;
    logic             result_fire;
    logic             out_full;
    afc_pkg::result_t result;
    afc_pkg::result_t out_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_value_reg <= afc_pkg::CMD_RESET;
        end else begin
            if (cfg_wr_en) begin
                cmd_value_reg <= cfg_wr_data;
            end
        end
    end

    // hold only when byte 16 may be next and the result slot stays occupied
    assign s_ready = !(at_last_byte && out_full && !m_ready);

    afc_frame u_frame (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .byte_fire        (s_valid && s_ready),
        .rx_byte          (s_rx_byte),
        .frame_start      (s_frame_start),
        .expected_command (cmd_value_reg),
        .at_last_byte     (at_last_byte),
        .result_fire      (result_fire),
        .result           (result)
    );

    afc_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (result_fire),
        .load_data (result),
        .m_ready   (m_ready),
        .full      (out_full),
        .m_valid   (m_valid),
        .m_data    (out_data)
    );

    assign m_angle_x      = out_data.angle_x;
    assign m_angle_y      = out_data.angle_y;
    assign m_angle_z      = out_data.angle_z;
    assign m_status       = 2'(out_data.status);
    assign m_sensor_error = out_data.sensor_error;
    assign m_valid_res    = out_data.valid_res;

endmodule
